FILE: hdl/jtag_tap_command_sequencer_defines.svh
// ----------------------------------------------------------------------------
// jtag_tap_command_sequencer_defines.svh
// Assertion macros shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef JTAG_TAP_COMMAND_SEQUENCER_DEFINES_SVH
`define JTAG_TAP_COMMAND_SEQUENCER_DEFINES_SVH

// same-cycle implication
`define JTSQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define JTSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/jtsq_pkg.sv
// ----------------------------------------------------------------------------
// jtsq_pkg
// Shared types and constants of the JTAG TAP command sequencer.
// ----------------------------------------------------------------------------
package jtsq_pkg;

	localparam int WORD_BITS_DEF     = 32;
	localparam int MAX_RUN_TICKS_DEF = 64;
	localparam int FIELD_BITS        = 32;

	localparam int OP_W  = 3;
	localparam int CNT_W = 7;
	localparam int PC_W  = 6;

	localparam logic [OP_W-1:0] OP_RESET     = 3'd0;
	localparam logic [OP_W-1:0] OP_IR_SHIFT  = 3'd1;
	localparam logic [OP_W-1:0] OP_DR_SHIFT  = 3'd2;
	localparam logic [OP_W-1:0] OP_IR_PAUSE  = 3'd3;
	localparam logic [OP_W-1:0] OP_DR_PAUSE  = 3'd4;
	localparam logic [OP_W-1:0] OP_RUNTEST   = 3'd5;

	// tick source of a microcode step
	typedef enum logic [1:0] {
		K_CONST,
		K_DATA,
		K_RUN
	} kind_t;

	// step condition; C_CNT repeats the step while the loop count is nonzero
	typedef enum logic [1:0] {
		C_ALWAYS,
		C_FIRST,
		C_LAST,
		C_CNT
	} cond_t;

	typedef struct packed {
		kind_t kind;
		cond_t cond;
		logic  tms;
		logic  fin;
	} ucode_t;

	// sequencer -> datapath
	typedef struct packed {
		logic  load;
		logic  emit;
		logic  step_loop;
		kind_t kind;
		logic  tms_bit;
	} ctl_t;

	// datapath -> sequencer
	typedef struct packed {
		logic out_free;
		logic loop_nz;
		logic loop_one;
		logic first;
		logic last;
	} stat_t;

endpackage

FILE: hdl/jtag_tap_command_sequencer.sv
// ----------------------------------------------------------------------------
// jtag_tap_command_sequencer
// Microcoded JTAG master: turns TAP commands into one TMS/TDI pair per tick.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------
//   in      | input     | in_valid / in_ready    | opcode first_word last_word
//           |           |                        | bit_count shift_word
//   out     | output    | out_valid / out_ready  | tms tdi end_of_item
//
// The command is loaded first, then one microcode step runs per cycle while the
// output register is free; each step that fires puts one tick in the output
// register. A header or tail step whose flag is clear, and an empty data loop,
// is skipped with no tick. A held output register stalls the step counter;
// in_ready stays low until the program ends. Reset clears the sequencer and
// output valid at once.
// ----------------------------------------------------------------------------
module jtag_tap_command_sequencer #(
	parameter int WORD_BITS     = jtsq_pkg::WORD_BITS_DEF,
	parameter int MAX_RUN_TICKS = jtsq_pkg::MAX_RUN_TICKS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [jtsq_pkg::OP_W-1:0]       opcode,
	input  logic                            first_word,
	input  logic                            last_word,
	input  logic [jtsq_pkg::CNT_W-1:0]      bit_count,
	input  logic [jtsq_pkg::FIELD_BITS-1:0] shift_word,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            tms,
	output logic                            tdi,
	output logic                            end_of_item
);

	logic                      busy_q;
	logic [jtsq_pkg::PC_W-1:0] pc_q;
	jtsq_pkg::ucode_t          cw;
	jtsq_pkg::ctl_t            ctl;
	jtsq_pkg::stat_t           stat;
	logic                      accept;
	logic                      known_op;
	logic                      cond_ok;
	logic                      advance;
	logic [jtsq_pkg::PC_W-1:0] entry;

	assign in_ready = !busy_q;
	assign accept   = in_valid && in_ready;
	assign known_op = opcode inside {[jtsq_pkg::OP_RESET:jtsq_pkg::OP_RUNTEST]};

	always_comb begin
		case (opcode)
			jtsq_pkg::OP_RESET:    entry = 6'd0;
			jtsq_pkg::OP_IR_SHIFT: entry = 6'd6;
			jtsq_pkg::OP_DR_SHIFT: entry = 6'd14;
			jtsq_pkg::OP_IR_PAUSE: entry = 6'd21;
			jtsq_pkg::OP_DR_PAUSE: entry = 6'd29;
			jtsq_pkg::OP_RUNTEST:  entry = 6'd37;
			default:               entry = 6'd0;
		endcase
	end

	jtsq_ucode_rom u_rom (
		.pc (pc_q),
		.cw (cw)
	);

	always_comb begin
		case (cw.cond)
			jtsq_pkg::C_FIRST: cond_ok = stat.first;
			jtsq_pkg::C_LAST:  cond_ok = stat.last;
			jtsq_pkg::C_CNT:   cond_ok = stat.loop_nz;
			default:           cond_ok = 1'b1;
		endcase
	end

	// a step whose condition fails is skipped; a loop step holds until count 1
	assign advance = busy_q && (!cond_ok || (stat.out_free
		&& (cw.cond != jtsq_pkg::C_CNT || stat.loop_one)));

	assign ctl.load      = accept && known_op;
	assign ctl.emit      = busy_q && cond_ok && stat.out_free;
	assign ctl.step_loop = ctl.emit && (cw.cond == jtsq_pkg::C_CNT);
	assign ctl.kind      = cw.kind;
	assign ctl.tms_bit   = cw.tms;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= '0;
		end else if (ctl.load) begin
			busy_q <= 1'b1;
			pc_q   <= entry;
		end else if (advance) begin
			if (cw.fin) begin
				busy_q <= 1'b0;
			end
			pc_q <= pc_q + 6'd1;
		end
	end

	jtsq_datapath #(
		.WORD_BITS     (WORD_BITS),
		.MAX_RUN_TICKS (MAX_RUN_TICKS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.opcode      (opcode),
		.first_word  (first_word),
		.last_word   (last_word),
		.bit_count   (bit_count),
		.shift_word  (shift_word),
		.stat        (stat),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.tms         (tms),
		.tdi         (tdi),
		.end_of_item (end_of_item)
	);

endmodule

FILE: hdl/jtsq_ucode_rom.sv
// ----------------------------------------------------------------------------
// jtsq_ucode_rom
// Microprogram store: one control word per step for every opcode.
// ----------------------------------------------------------------------------
module jtsq_ucode_rom (
	input  logic [jtsq_pkg::PC_W-1:0] pc,
	output jtsq_pkg::ucode_t          cw
);

	function automatic jtsq_pkg::ucode_t mk(jtsq_pkg::kind_t k, jtsq_pkg::cond_t c,
			logic t, logic f);
		jtsq_pkg::ucode_t w;
		w.kind = k;
		w.cond = c;
		w.tms  = t;
		w.fin  = f;
		return w;
	endfunction

	always_comb begin
		case (pc)
			// TAP reset: five high, one low
			6'd0:  cw = mk(jtsq_pkg::K_CONST, jtsq_pkg::C_ALWAYS, 1'b1, 1'b0);
			6'd1:  cw = mk(jtsq_pkg::K_CONST, jtsq_pkg::C_ALWAYS, 1'b1, 1'b0);
			6'd2:  cw = mk(jtsq_pkg::K_CONST, jtsq_pkg::C_ALWAYS, 1'b1, 1'b0);
			6'd3:  cw = mk(jtsq_pkg::K_CONST, jtsq_pkg::C_ALWAYS, 1'b1, 1'b0);
			6'd4:  cw = mk(jtsq_pkg::K_CONST, jtsq_pkg::C_ALWAYS, 1'b1, 1'b0);
			6'd5:  cw = mk(jtsq_pkg::K_CONST, jtsq_pkg::C_ALWAYS, 1'b0, 1'b1);
			// IR shift to idle
			6'd6:  cw = mk(jtsq_pkg::K_CONST, jtsq_pkg::C_FIRST, 1'b0, 1'b0);
			6'd7:  cw = mk(jtsq_pkg::K_CONST, jtsq_pkg::C_FIRST, 1'b1, 1'b0);
			6'd8:  cw = mk(jtsq_pkg::K_CONST, jtsq_pkg::C_FIRST, 1'b1, 1'b0);
			6'd9:  cw = mk(jtsq_pkg::K_CONST, jtsq_pkg::C_FIRST, 1'b0, 1'b0);
			6'd10: cw = mk(jtsq_pkg::K_CONST, jtsq_pkg::C_FIRST, 1'b0, 1'b0);
			6'd11: cw = mk(jtsq_pkg::K_DATA,  jtsq_pkg::C_CNT,   1'b0, 1'b0);
			6'd12: cw = mk(jtsq_pkg::K_CONST, jtsq_pkg::C_LAST,  1'b1, 1'b0);
			6'd13: cw = mk(jtsq_pkg::K_CONST, jtsq_pkg::C_LAST,  1'b0, 1'b1);
			// DR shift to idle
			6'd14: cw = mk(jtsq_pkg::K_CONST, jtsq_pkg::C_FIRST, 1'b0, 1'b0);
			6'd15: cw = mk(jtsq_pkg::K_CONST, jtsq_pkg::C_FIRST, 1'b1, 1'b0);
			6'd16: cw = mk(jtsq_pkg::K_CONST, jtsq_pkg::C_FIRST, 1'b0, 1'b0);
			6'd17: cw = mk(jtsq_pkg::K_CONST, jtsq_pkg::C_FIRST, 1'b0, 1'b0);
			6'd18: cw = mk(jtsq_pkg::K_DATA,  jtsq_pkg::C_CNT,   1'b0, 1'b0);
			6'd19: cw = mk(jtsq_pkg::K_CONST, jtsq_pkg::C_LAST,  1'b1, 1'b0);
			6'd20: cw = mk(jtsq_pkg::K_CONST, jtsq_pkg::C_LAST,  1'b0, 1'b1);
			// IR shift stopping in Pause-IR
			6'd21: cw = mk(jtsq_pkg::K_CONST, jtsq_pkg::C_FIRST, 1'b0, 1'b0);
			6'd22: cw = mk(jtsq_pkg::K_CONST, jtsq_pkg::C_FIRST, 1'b1, 1'b0);
			6'd23: cw = mk(jtsq_pkg::K_CONST, jtsq_pkg::C_FIRST, 1'b1, 1'b0);
			6'd24: cw = mk(jtsq_pkg::K_CONST, jtsq_pkg::C_FIRST, 1'b0, 1'b0);
			6'd25: cw = mk(jtsq_pkg::K_CONST, jtsq_pkg::C_FIRST, 1'b0, 1'b0);
			6'd26: cw = mk(jtsq_pkg::K_DATA,  jtsq_pkg::C_CNT,   1'b0, 1'b0);
			6'd27: cw = mk(jtsq_pkg::K_CONST, jtsq_pkg::C_LAST,  1'b0, 1'b0);
			6'd28: cw = mk(jtsq_pkg::K_CONST, jtsq_pkg::C_LAST,  1'b0, 1'b1);
			// DR shift starting from Pause-IR
			6'd29: cw = mk(jtsq_pkg::K_CONST, jtsq_pkg::C_FIRST, 1'b1, 1'b0);
			6'd30: cw = mk(jtsq_pkg::K_CONST, jtsq_pkg::C_FIRST, 1'b1, 1'b0);
			6'd31: cw = mk(jtsq_pkg::K_CONST, jtsq_pkg::C_FIRST, 1'b1, 1'b0);
			6'd32: cw = mk(jtsq_pkg::K_CONST, jtsq_pkg::C_FIRST, 1'b0, 1'b0);
			6'd33: cw = mk(jtsq_pkg::K_CONST, jtsq_pkg::C_FIRST, 1'b0, 1'b0);
			6'd34: cw = mk(jtsq_pkg::K_DATA,  jtsq_pkg::C_CNT,   1'b0, 1'b0);
			6'd35: cw = mk(jtsq_pkg::K_CONST, jtsq_pkg::C_LAST,  1'b1, 1'b0);
			6'd36: cw = mk(jtsq_pkg::K_CONST, jtsq_pkg::C_LAST,  1'b0, 1'b1);
			// run-test idle clocks
			6'd37: cw = mk(jtsq_pkg::K_RUN,   jtsq_pkg::C_CNT,   1'b0, 1'b1);
			// unused addresses end the program at once
			default: cw = mk(jtsq_pkg::K_CONST, jtsq_pkg::C_FIRST, 1'b0, 1'b1);
		endcase
	end

endmodule

FILE: hdl/jtsq_datapath.sv
// ----------------------------------------------------------------------------
// jtsq_datapath
// Shift register, loop and tick counters, and the output register.
// ----------------------------------------------------------------------------
module jtsq_datapath #(
	parameter int WORD_BITS     = jtsq_pkg::WORD_BITS_DEF,
	parameter int MAX_RUN_TICKS = jtsq_pkg::MAX_RUN_TICKS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  jtsq_pkg::ctl_t                      ctl,
	input  logic [jtsq_pkg::OP_W-1:0]           opcode,
	input  logic                                first_word,
	input  logic                                last_word,
	input  logic [jtsq_pkg::CNT_W-1:0]          bit_count,
	input  logic [jtsq_pkg::FIELD_BITS-1:0]     shift_word,
	output jtsq_pkg::stat_t                     stat,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                tms,
	output logic                                tdi,
	output logic                                end_of_item
);

	localparam int DATA_MAX = (WORD_BITS < jtsq_pkg::FIELD_BITS) ? WORD_BITS
		: jtsq_pkg::FIELD_BITS;
	localparam logic [jtsq_pkg::CNT_W-1:0] DATA_LIM = jtsq_pkg::CNT_W'(DATA_MAX);
	localparam logic [jtsq_pkg::CNT_W-1:0] RUN_LIM  = jtsq_pkg::CNT_W'(MAX_RUN_TICKS);

	logic [DATA_MAX-1:0]        shift_q;
	logic [jtsq_pkg::CNT_W-1:0] loop_q;
	logic [jtsq_pkg::CNT_W-1:0] remain_q;
	logic                       first_q;
	logic                       last_q;
	logic                       out_valid_q;
	logic                       tms_q;
	logic                       tdi_q;
	logic                       eoi_q;

	logic [jtsq_pkg::CNT_W-1:0] n_shift;
	logic [jtsq_pkg::CNT_W-1:0] n_run;
	logic [jtsq_pkg::CNT_W-1:0] head_n;
	logic [jtsq_pkg::CNT_W-1:0] total;
	logic                       tick_tms;
	logic                       tick_tdi;

	assign n_shift = (bit_count > DATA_LIM) ? DATA_LIM : bit_count;
	assign n_run   = (bit_count > RUN_LIM) ? RUN_LIM : bit_count;

	always_comb begin
		case (opcode)
			jtsq_pkg::OP_DR_SHIFT: head_n = 7'd4;
			default:               head_n = 7'd5;
		endcase
		case (opcode)
			jtsq_pkg::OP_RESET:   total = 7'd6;
			jtsq_pkg::OP_RUNTEST: total = n_run;
			default:              total = (first_word ? head_n : 7'd0) + n_shift
				+ (last_word ? 7'd2 : 7'd0);
		endcase
	end

	assign stat.out_free = !out_valid_q || out_ready;
	assign stat.loop_nz  = (loop_q != '0);
	assign stat.loop_one = (loop_q == 7'd1);
	assign stat.first    = first_q;
	assign stat.last     = last_q;

	always_comb begin
		case (ctl.kind)
			jtsq_pkg::K_DATA: begin
				tick_tms = last_q && (loop_q == 7'd1);
				tick_tdi = shift_q[0];
			end
			jtsq_pkg::K_RUN: begin
				tick_tms = 1'b0;
				tick_tdi = 1'b0;
			end
			default: begin
				tick_tms = ctl.tms_bit;
				tick_tdi = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_q      <= '0;
			remain_q    <= '0;
			first_q     <= 1'b0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.load) begin
				loop_q   <= (opcode == jtsq_pkg::OP_RUNTEST) ? n_run : n_shift;
				remain_q <= total;
				first_q  <= first_word;
				last_q   <= last_word;
			end else begin
				if (ctl.step_loop) begin
					loop_q <= loop_q - 7'd1;
				end
				if (ctl.emit) begin
					remain_q <= remain_q - 7'd1;
				end
			end
			if (ctl.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			shift_q <= shift_word[DATA_MAX-1:0];
		end else if (ctl.step_loop) begin
			shift_q <= shift_q >> 1;
		end
		if (ctl.emit) begin
			tms_q <= tick_tms;
			tdi_q <= tick_tdi;
			eoi_q <= (remain_q == 7'd1);
		end
	end

	assign out_valid   = out_valid_q;
	assign tms         = tms_q;
	assign tdi         = tdi_q;
	assign end_of_item = eoi_q;

endmodule

FILE: hdl/jtsq_checker.sv
// ----------------------------------------------------------------------------
// jtsq_checker
// Port-level checks of the command sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`include "jtag_tap_command_sequencer_defines.svh"

module jtsq_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic [jtsq_pkg::OP_W-1:0]       opcode,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic                            tms,
	input logic                            tdi,
	input logic                            end_of_item
);

	// a stalled tick holds
	`JTSQ_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(tms) && $stable(tdi) && $stable(end_of_item), "output tick changed while stalled")

	// a TAP reset always keeps the sequencer busy for a while
	`JTSQ_ASSERT_NEXT(a_reset_busy, clk, arst_n, in_valid && in_ready && opcode == jtsq_pkg::OP_RESET, !in_ready, "reset command did not start the sequencer")

	// unknown opcodes are dropped without starting a program
	`JTSQ_ASSERT_NEXT(a_bad_op_drop, clk, arst_n, in_valid && in_ready && opcode > jtsq_pkg::OP_RUNTEST, in_ready, "unknown opcode started the sequencer")

	// an idle sequencer only leaves idle on an accepted transaction
	`JTSQ_ASSERT_NEXT(a_idle_stays, clk, arst_n, in_ready && !in_valid, in_ready, "sequencer went busy without a transaction")

endmodule

bind jtag_tap_command_sequencer jtsq_checker u_jtsq_checker (.*);

FILE: sim/jtsq_tick_checker.sv
// ----------------------------------------------------------------------------
// jtsq_tick_checker
// Watches both channels of the JTAG TAP command sequencer. Every accepted
// command is expanded into the TMS/TDI ticks it must produce. Every accepted
// tick is compared field by field with the oldest expected tick.
// ----------------------------------------------------------------------------
module jtsq_tick_checker #(
	parameter int WORD_BITS     = jtsq_pkg::WORD_BITS_DEF,
	parameter int MAX_RUN_TICKS = jtsq_pkg::MAX_RUN_TICKS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic [jtsq_pkg::OP_W-1:0]       opcode,
	input  logic                            first_word,
	input  logic                            last_word,
	input  logic [jtsq_pkg::CNT_W-1:0]      bit_count,
	input  logic [jtsq_pkg::FIELD_BITS-1:0] shift_word,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic                            tms,
	input  logic                            tdi,
	input  logic                            end_of_item,
	output int                              fail_count,
	output int                              pending,
	output int                              ticks_checked
);

	localparam int DATA_BITS = (WORD_BITS < jtsq_pkg::FIELD_BITS) ? WORD_BITS
		: jtsq_pkg::FIELD_BITS;
	localparam int MAX_PRINTS = 40;

	typedef struct packed {
		logic tms;
		logic tdi;
		logic eoi;
	} tick_t;

	tick_t tick_q[$];
	tick_t want;
	int    errors = 0;
	int    ticks = 0;

	assign fail_count    = errors;
	assign ticks_checked = ticks;

	function automatic void push_tick(input logic t, input logic d);
		tick_t nt;
		nt.tms = t;
		nt.tdi = d;
		nt.eoi = 1'b0;
		tick_q.push_back(nt);
	endfunction

	// expand one command into its expected ticks
	function automatic void expand_command(
		input logic [jtsq_pkg::OP_W-1:0]       op,
		input logic                            fw,
		input logic                            lw,
		input logic [jtsq_pkg::CNT_W-1:0]      cnt,
		input logic [jtsq_pkg::FIELD_BITS-1:0] word
	);
		logic [4:0] head;
		logic [1:0] tail;
		int         head_n;
		int         n;
		int         base;
		int         i;
		bit         is_shift;
		base     = tick_q.size();
		is_shift = 1'b0;
		head     = '0;
		tail     = '0;
		head_n   = 5;
		case (op)
			jtsq_pkg::OP_RESET: begin
				for (i = 0; i < 5; i++)
					push_tick(1'b1, 1'b0);
				push_tick(1'b0, 1'b0);
			end
			// header/tail TMS patterns, bit 0 goes out first
			jtsq_pkg::OP_IR_SHIFT: begin
				is_shift = 1'b1;
				head = 5'b00110;
				tail = 2'b01;
			end
			jtsq_pkg::OP_DR_SHIFT: begin
				is_shift = 1'b1;
				head = 5'b00010;
				head_n = 4;
				tail = 2'b01;
			end
			jtsq_pkg::OP_IR_PAUSE: begin
				is_shift = 1'b1;
				head = 5'b00110;
				tail = 2'b00;
			end
			jtsq_pkg::OP_DR_PAUSE: begin
				is_shift = 1'b1;
				head = 5'b00111;
				tail = 2'b01;
			end
			jtsq_pkg::OP_RUNTEST: begin
				n = (int'(cnt) > MAX_RUN_TICKS) ? MAX_RUN_TICKS : int'(cnt);
				for (i = 0; i < n; i++)
					push_tick(1'b0, 1'b0);
			end
			default: ;
		endcase
		if (is_shift) begin
			n = (int'(cnt) > DATA_BITS) ? DATA_BITS : int'(cnt);
			if (fw)
				for (i = 0; i < head_n; i++)
					push_tick(head[i], 1'b0);
			for (i = 0; i < n; i++)
				push_tick(lw && (i == n - 1), word[i]);
			if (lw)
				for (i = 0; i < 2; i++)
					push_tick(tail[i], 1'b0);
		end
		if (tick_q.size() > base)
			tick_q[tick_q.size() - 1].eoi = 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input logic expv, input logic gotv);
		if (errors < MAX_PRINTS)
			$display("%0t: tick %0d %s: expected %b, got %b", $time, ticks, what, expv, gotv);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q.delete();
			pending <= 0;
		end else begin
			if (in_valid && in_ready)
				expand_command(opcode, first_word, last_word, bit_count, shift_word);
			if (out_valid && out_ready) begin
				if (tick_q.size() == 0) begin
					report_mismatch("arrived with nothing expected, tms", 1'bx, tms);
				end else begin
					want = tick_q.pop_front();
					if (tms !== want.tms)
						report_mismatch("tms", want.tms, tms);
					if (tdi !== want.tdi)
						report_mismatch("tdi", want.tdi, tdi);
					if (end_of_item !== want.eoi)
						report_mismatch("end_of_item", want.eoi, end_of_item);
				end
				ticks++;
			end
			pending <= tick_q.size();
		end
	end

endmodule

FILE: sim/tb_jtag_tap_command_sequencer.sv
// ----------------------------------------------------------------------------
// tb_jtag_tap_command_sequencer
// Drives JTAG commands into the sequencer: a directed set covering every
// opcode, flag combination, empty and oversized words and clamped runtests,
// then random shift chains, runtests, resets and noise. Both channels idle
// at random; the checker beside the block predicts and compares every tick.
// ----------------------------------------------------------------------------
module tb_jtag_tap_command_sequencer;

	localparam int                         N_ITEMS     = 500;
	localparam int                         STALL_LIMIT = 1000;
	localparam int                         DRAIN_EVERY = 120;
	localparam int                         SETTLE      = 64;
	localparam logic [jtsq_pkg::OP_W-1:0]  OP_SPARE_LO = 3'd6;
	localparam logic [jtsq_pkg::OP_W-1:0]  OP_SPARE_HI = 3'd7;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            in_valid = 1'b0;
	logic                            in_ready;
	logic [jtsq_pkg::OP_W-1:0]       opcode = '0;
	logic                            first_word = 1'b0;
	logic                            last_word = 1'b0;
	logic [jtsq_pkg::CNT_W-1:0]      bit_count = '0;
	logic [jtsq_pkg::FIELD_BITS-1:0] shift_word = '0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	logic                            tms;
	logic                            tdi;
	logic                            end_of_item;

	int fail_count;
	int pending;
	int ticks_checked;
	int idle_cycles = 0;
	int items_done = 0;
	int items_ignored = 0;
	int drains = 0;
	bit no_idle = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	jtag_tap_command_sequencer uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.first_word  (first_word),
		.last_word   (last_word),
		.bit_count   (bit_count),
		.shift_word  (shift_word),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.tms         (tms),
		.tdi         (tdi),
		.end_of_item (end_of_item)
	);

	jtsq_tick_checker u_tick_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.opcode        (opcode),
		.first_word    (first_word),
		.last_word     (last_word),
		.bit_count     (bit_count),
		.shift_word    (shift_word),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.tms           (tms),
		.tdi           (tdi),
		.end_of_item   (end_of_item),
		.fail_count    (fail_count),
		.pending       (pending),
		.ticks_checked (ticks_checked)
	);

	// mostly short gaps, now and then a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	task automatic send_cmd(
		input logic [jtsq_pkg::OP_W-1:0]       op,
		input logic                            fw,
		input logic                            lw,
		input logic [jtsq_pkg::CNT_W-1:0]      cnt,
		input logic [jtsq_pkg::FIELD_BITS-1:0] word
	);
		int gap;
		in_valid   <= 1'b1;
		opcode     <= op;
		first_word <= fw;
		last_word  <= lw;
		bit_count  <= cnt;
		shift_word <= word;
		do @(posedge clk); while (!in_ready);
		if (op > jtsq_pkg::OP_RUNTEST || (op == jtsq_pkg::OP_RUNTEST && cnt == 0) ||
				(op != jtsq_pkg::OP_RESET && op != jtsq_pkg::OP_RUNTEST && cnt == 0
				&& !fw && !lw))
			items_ignored++;
		else
			items_done++;
		gap = idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// receiver back-pressure
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = idle_len();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == STALL_LIMIT) begin
			$display("timeout: no transaction for %0d cycles, %0d ticks pending",
				STALL_LIMIT, pending);
			$display("jtag_tap_command_sequencer: mismatch");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		logic [jtsq_pkg::OP_W-1:0]  op;
		logic [jtsq_pkg::CNT_W-1:0] cnt;
		int                         nwords;
		int                         w;
		int                         r;
		int                         next_drain;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed
		send_cmd(jtsq_pkg::OP_RESET, 1'b1, 1'b1, 7'd127, 32'hFFFF_FFFF);
		send_cmd(jtsq_pkg::OP_IR_SHIFT, 1'b1, 1'b1, 7'd32, 32'hFFFF_FFFF);
		send_cmd(jtsq_pkg::OP_DR_SHIFT, 1'b1, 1'b1, 7'd32, 32'h0000_0000);
		send_cmd(jtsq_pkg::OP_IR_PAUSE, 1'b1, 1'b1, 7'd32, 32'hA5A5_A5A5);
		send_cmd(jtsq_pkg::OP_DR_PAUSE, 1'b1, 1'b1, 7'd32, 32'h5A5A_5A5A);
		send_cmd(jtsq_pkg::OP_IR_SHIFT, 1'b1, 1'b0, 7'd32, 32'h1234_5678);
		send_cmd(jtsq_pkg::OP_IR_SHIFT, 1'b0, 1'b0, 7'd16, 32'h8765_4321);
		send_cmd(jtsq_pkg::OP_IR_SHIFT, 1'b0, 1'b1, 7'd1, 32'h0000_0001);
		// zero-length words: header and tail only, or nothing at all
		send_cmd(jtsq_pkg::OP_DR_SHIFT, 1'b1, 1'b0, 7'd0, 32'hFFFF_FFFF);
		send_cmd(jtsq_pkg::OP_DR_SHIFT, 1'b0, 1'b1, 7'd0, 32'hFFFF_FFFF);
		send_cmd(jtsq_pkg::OP_IR_PAUSE, 1'b1, 1'b1, 7'd0, 32'h0F0F_0F0F);
		send_cmd(jtsq_pkg::OP_DR_PAUSE, 1'b0, 1'b0, 7'd0, 32'hFFFF_FFFF);
		// oversized words clamp to the word width
		send_cmd(jtsq_pkg::OP_DR_SHIFT, 1'b1, 1'b1, 7'd64, 32'hDEAD_BEEF);
		send_cmd(jtsq_pkg::OP_IR_SHIFT, 1'b0, 1'b1, 7'd127, 32'hC3C3_3C3C);
		send_cmd(jtsq_pkg::OP_IR_PAUSE, 1'b1, 1'b0, 7'd33, 32'h8000_0001);
		send_cmd(jtsq_pkg::OP_DR_PAUSE, 1'b1, 1'b1, 7'd1, 32'h0000_0000);
		// runtest, including clamped lengths
		send_cmd(jtsq_pkg::OP_RUNTEST, 1'b0, 1'b0, 7'd0, 32'h0);
		send_cmd(jtsq_pkg::OP_RUNTEST, 1'b1, 1'b1, 7'd1, 32'hFFFF_FFFF);
		send_cmd(jtsq_pkg::OP_RUNTEST, 1'b0, 1'b1, 7'd64, 32'h0);
		send_cmd(jtsq_pkg::OP_RUNTEST, 1'b1, 1'b0, 7'd65, 32'h0);
		send_cmd(jtsq_pkg::OP_RUNTEST, 1'b0, 1'b0, 7'd127, 32'h0);
		// unknown opcodes
		send_cmd(OP_SPARE_LO, 1'b1, 1'b1, 7'd32, 32'h5555_5555);
		send_cmd(OP_SPARE_HI, 1'b1, 1'b1, 7'd127, 32'hFFFF_FFFF);
		wait_drained();
		drains++;

		// random
		next_drain = items_done + DRAIN_EVERY;
		while (items_done < N_ITEMS) begin
			no_idle = (items_done >= 200 && items_done < 280);
			r = $urandom_range(0, 99);
			if (r < 60) begin
				op = jtsq_pkg::OP_W'($urandom_range(jtsq_pkg::OP_IR_SHIFT,
					jtsq_pkg::OP_DR_PAUSE));
				nwords = $urandom_range(1, 4);
				for (w = 0; w < nwords; w++) begin
					r = $urandom_range(0, 19);
					if (r == 0)
						cnt = '0;
					else if (r == 1)
						cnt = jtsq_pkg::CNT_W'($urandom_range(33, 127));
					else
						cnt = jtsq_pkg::CNT_W'($urandom_range(1, 32));
					send_cmd(op, w == 0, w == nwords - 1, cnt, $urandom);
				end
			end else if (r < 75) begin
				send_cmd(jtsq_pkg::OP_RUNTEST, 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), jtsq_pkg::CNT_W'($urandom_range(0, 127)),
					$urandom);
			end else if (r < 82) begin
				send_cmd(jtsq_pkg::OP_RESET, 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), jtsq_pkg::CNT_W'($urandom_range(0, 127)),
					$urandom);
			end else begin
				send_cmd(jtsq_pkg::OP_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), jtsq_pkg::CNT_W'($urandom_range(0, 127)),
					$urandom);
			end
			if (items_done >= next_drain) begin
				wait_drained();
				drains++;
				next_drain = items_done + DRAIN_EVERY;
			end
		end

		no_idle = 1'b0;
		wait_drained();
		repeat (SETTLE) @(posedge clk);

		$display("sent %0d commands plus %0d that yield no ticks, checked %0d ticks",
			items_done, items_ignored, ticks_checked);
		$display("idle/stall gaps on both channels, %0d full drains before new commands",
			drains);
		if (fail_count == 0)
			$display("jtag_tap_command_sequencer: match");
		else
			$display("jtag_tap_command_sequencer: mismatch");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+hdl
hdl/jtsq_pkg.sv
hdl/jtsq_ucode_rom.sv
hdl/jtsq_datapath.sv
hdl/jtag_tap_command_sequencer.sv
hdl/jtsq_checker.sv
sim/jtsq_tick_checker.sv
sim/tb_jtag_tap_command_sequencer.sv
